// ===== rtl/multi_reader_ring_pointer_manager_defines.svh =====
// ----------------------------------------------------------------------------
// Ring pointer manager assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef MULTI_READER_RING_POINTER_MANAGER_DEFINES_SVH
`define MULTI_READER_RING_POINTER_MANAGER_DEFINES_SVH

// check while out of reset
`define MRRPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge
`define MRRPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mrrpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring pointer manager package
// Shared codes, widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mrrpm_pkg;

  localparam int ADDR_BITS = 16;
  localparam logic [16:0] RING_MAX = 17'h10000;

  localparam logic [2:0] ACT_ADD      = 3'd0;
  localparam logic [2:0] ACT_REQUEST  = 3'd1;
  localparam logic [2:0] ACT_WROTE    = 3'd2;
  localparam logic [2:0] ACT_WRAP     = 3'd3;
  localparam logic [2:0] ACT_JOIN     = 3'd4;
  localparam logic [2:0] ACT_NEXT     = 3'd5;
  localparam logic [2:0] ACT_CONSUMED = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVERRUN = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/multi_reader_ring_pointer_manager.sv =====
// ----------------------------------------------------------------------------
// Multi-reader ring pointer manager
// Head, lap and written-end tracking for one writer and many reader slots.
//
// Channel   Dir  Contents
// in_       in   tdata: length; tuser: action, reader, replay
// out_      out  tdata: offsets, lengths, laps; tuser: status
// cfg_      in   APB register ring_bytes at address 0
//
// Each request passes through accept, slot memory read and execute.
// The read of the reader slot memory is registered.
// A new request is taken while a finished result waits at the output.
// Execute holds while the output register is full and not being read.
// Reset is synchronous; no clearing pass is run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module multi_reader_ring_pointer_manager
  import mrrpm_pkg::*;
#(
  parameter int READERS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // length[16:0]
  input  logic [6:0]   in_tuser,   // action[2:0], reader[5:3], replay[6]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // block_offset[15:0], block_bytes[32:16],
                                   // block_lap[64:33], head_offset[80:65],
                                   // head_lap[112:81]
  output logic [1:0]   out_tuser,  // status[1:0]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  ctl_t        ctl;
  sts_t        sts;
  logic        cfg_we;
  logic [16:0] ring_bytes;

  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 3'd0);
  assign cfg_prdata = (cfg_paddr == 3'd0) ? {15'd0, ring_bytes} : 32'd0;

  mrrpm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .sts(sts), .ctl(ctl)
  );

  mrrpm_dp #(.READERS(READERS)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_pwdata[16:0]), .ring_bytes(ring_bytes),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

// ===== rtl/mrrpm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mrrpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mrrpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ring pointer manager controller
// Sequences each request through slot read and execute.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "multi_reader_ring_pointer_manager_defines.svh"
module mrrpm_ctrl
  import mrrpm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output ctl_t ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EX   = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign ctl.load  = in_tvalid && in_tready;
  assign ctl.exec  = (state_r == S_EX) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_RD;
      S_RD:   state_nxt = S_EX;
      S_EX:   if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MRRPM_ASSERT(a_acc_rd, in_tvalid && in_tready |=> state_r == S_RD, "accept must read slot")
  `MRRPM_ASSERT(a_rd_ex, state_r == S_RD |=> state_r == S_EX, "read must lead to execute")
  `MRRPM_ASSERT(a_ex_hold, state_r == S_EX && !sts.out_free |=> state_r == S_EX,
                "execute must hold while output is full")

endmodule

// ===== rtl/mrrpm_dp.sv =====
// ----------------------------------------------------------------------------
// Ring pointer manager datapath
// Writer pointers, reader slot store, command evaluation and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mrrpm_dp
  import mrrpm_pkg::*;
#(
  parameter int READERS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ctl_t          ctl,
  output sts_t          sts,
  input  logic [23:0]   in_tdata,
  input  logic [6:0]    in_tuser,
  input  logic          cfg_we,
  input  logic [16:0]   cfg_wdata,
  output logic [16:0]   ring_bytes,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [119:0]  out_tdata,
  output logic [1:0]    out_tuser
);

  localparam int RA = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int SW = 16 + 32 + 17;

  logic [16:0] ring_r;
  logic [15:0] head_r, head_nxt;
  logic [31:0] lap_r, lap_nxt;
  logic [16:0] wend_r, wend_nxt;
  logic        wv_r, wv_nxt;
  logic [15:0] ws_r, ws_nxt;
  logic [2:0]  act_r;
  logic [16:0] len_r;
  logic [2:0]  rdr_r;
  logic        rep_r;
  logic        ov_r;
  logic [119:0] od_r;
  logic [1:0]  ou_r;

  logic [SW-1:0] rd_q, wr_d;
  logic          slot_we;
  logic [RA-1:0] slot_a;

  logic [16:0] s;
  logic [1:0]  status;
  logic [15:0] boff;
  logic [16:0] bbytes;
  logic [31:0] blap;

  assign slot_a = RA'(rdr_r);

  mrrpm_ram #(.WIDTH(SW), .DEPTH(READERS)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_a), .wdata(wr_d), .raddr(slot_a), .rdata(rd_q)
  );

  assign s = (ring_r == 17'd0) ? 17'd1 : ((ring_r > RING_MAX) ? RING_MAX : ring_r);
  assign sts.out_free = !ov_r || out_tready;
  assign ring_bytes = ring_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

  always_comb begin
    logic [16:0] avail, nh, hs, half;
    logic [15:0] off;
    logic [31:0] rl, rl1;
    logic [16:0] pend, npend;
    logic [17:0] noff;
    logic        commit;
    avail = s - {1'b0, head_r};
    nh = 17'd0;
    hs = 17'd0;
    half = s >> 1;
    off = rd_q[15:0];
    rl = rd_q[47:16];
    pend = rd_q[64:48];
    rl1 = rl + 32'd1;
    noff = {2'b0, off} + {1'b0, len_r};
    npend = (pend > len_r) ? pend - len_r : 17'd0;
    commit = 1'b0;
    head_nxt = head_r;
    lap_nxt = lap_r;
    wend_nxt = wend_r;
    wv_nxt = wv_r;
    ws_nxt = ws_r;
    status = ST_OK;
    boff = 16'd0;
    bbytes = 17'd0;
    blap = 32'd0;
    unique case (act_r)
      ACT_ADD, ACT_WROTE: begin
        if (len_r > s || (act_r == ACT_WROTE && (!wv_r || ws_r != head_r || len_r > avail)))
        begin
          status = ST_ERROR;
        end else if (avail >= len_r) begin
          nh = {1'b0, head_r} + len_r;
          if (nh == s) begin
            lap_nxt = lap_r + 32'd1;
            head_nxt = 16'd0;
            wend_nxt = s;
          end else begin
            head_nxt = nh[15:0];
            if (wend_r < nh) wend_nxt = nh;
          end
        end else begin
          wend_nxt = s;
          lap_nxt = lap_r + 32'd1;
          hs = len_r - avail;
          head_nxt = hs[15:0];
        end
      end
      ACT_REQUEST: begin
        if (len_r > s) begin
          status = ST_ERROR;
        end else begin
          if (avail < len_r) begin
            wend_nxt = {1'b0, head_r};
            head_nxt = 16'd0;
            lap_nxt = lap_r + 32'd1;
          end
          wv_nxt = 1'b1;
          ws_nxt = head_nxt;
          boff = head_nxt;
          bbytes = s - {1'b0, head_nxt};
          blap = lap_nxt;
        end
      end
      ACT_WRAP: begin
        wend_nxt = {1'b0, head_r};
        head_nxt = 16'd0;
        lap_nxt = lap_r + 32'd1;
      end
      ACT_JOIN, ACT_NEXT, ACT_CONSUMED: begin
        if (32'(rdr_r) >= READERS) begin
          status = ST_ERROR;
        end else begin
          commit = 1'b1;
          if (act_r == ACT_JOIN) begin
            rl = lap_r;
            off = head_r;
            pend = 17'd0;
            if (rep_r) begin
              if ({1'b0, head_r} >= half) begin
                hs = {1'b0, head_r} - half;
                off = hs[15:0];
              end else if (lap_r == 32'd0) begin
                off = 16'd0;
              end else begin
                rl = lap_r - 32'd1;
                hs = {1'b0, head_r} + (wend_r >> 1);
                off = hs[15:0];
              end
            end
          end else if (lap_r > rl1 || (lap_r > rl && head_r > off)) begin
            status = ST_OVERRUN;
            off = head_r;
            rl = lap_r;
            pend = 17'd0;
          end else if (act_r == ACT_NEXT) begin
            if (head_r > off) begin
              pend = {1'b0, head_r - off};
            end else if (lap_r == rl1 && wend_r == {1'b0, off}) begin
              off = 16'd0;
              rl = rl1;
              pend = {1'b0, head_r};
            end else if (lap_r > rl) begin
              pend = (wend_r > {1'b0, off}) ? wend_r - {1'b0, off} : 17'd0;
            end
          end else begin
            if (noff > {1'b0, wend_r}) begin
              commit = 1'b0;
            end else if (noff == {1'b0, wend_r} && noff != {2'b0, head_r}) begin
              if (npend != 17'd0) begin
                commit = 1'b0;
              end else begin
                off = 16'd0;
                rl = rl1;
                pend = 17'd0;
              end
            end else begin
              off = noff[15:0];
              pend = npend;
            end
            if (!commit) status = ST_ERROR;
          end
          if (commit) begin
            boff = off;
            bbytes = pend;
            blap = rl;
          end
        end
      end
      default: status = ST_ERROR;
    endcase
    wr_d = {pend, rl, off};
    slot_we = ctl.exec && commit;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      len_r <= in_tdata[16:0];
      act_r <= in_tuser[2:0];
      rdr_r <= in_tuser[5:3];
      rep_r <= in_tuser[6];
    end
    if (ctl.exec) begin
      od_r <= {7'd0, lap_nxt, head_nxt, blap, bbytes, boff};
      ou_r <= status;
    end
    if (!rst_n) begin
      ring_r <= RING_MAX;
      head_r <= 16'd0;
      lap_r  <= 32'd0;
      wend_r <= 17'd0;
      wv_r   <= 1'b0;
      ws_r   <= 16'd0;
      ov_r   <= 1'b0;
    end else begin
      if (ctl.exec) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
      if (cfg_we) begin
        ring_r <= cfg_wdata;
      end
      if (ctl.exec) begin
        head_r <= head_nxt;
        lap_r  <= lap_nxt;
        wend_r <= wend_nxt;
        wv_r   <= wv_nxt;
        ws_r   <= ws_nxt;
      end else if (cfg_we) begin
        head_r <= 16'd0;
        lap_r  <= 32'd0;
        wend_r <= 17'd0;
        wv_r   <= 1'b0;
        ws_r   <= 16'd0;
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Ring pointer manager regression
// Drives writer and reader requests through the stream port and rewrites the
// ring size over APB. A scoreboard predicts every result and compares it
// field by field. The sender runs in bursts and the receiver stalls on a
// pattern, with one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import mrrpm_pkg::*;

  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam int NRD = 8;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] boff;
    logic [16:0] bbytes;
    logic [31:0] blap;
    logic [15:0] hoff;
    logic [31:0] hlap;
  } ring_result_t;

  class ring_scoreboard;
    ring_result_t pending_q[$];
    logic [16:0] ring_reg;
    longint unsigned head, wend, wblk_at;
    logic [31:0] lap;
    bit wblk_ok;
    longint unsigned rd_off[NRD];
    logic [31:0] rd_lap[NRD];
    longint unsigned rd_pend[NRD];
    int mismatches, checked, n_ovr, n_err;

    function new();
      ring_reg = 17'h10000;
      restart();
      for (int i = 0; i < NRD; i++) begin
        rd_off[i] = 0;
        rd_lap[i] = 0;
        rd_pend[i] = 0;
      end
      mismatches = 0;
      checked = 0;
      n_ovr = 0;
      n_err = 0;
    endfunction

    function void restart();
      head = 0;
      lap = 0;
      wend = 0;
      wblk_ok = 0;
      wblk_at = 0;
    endfunction

    function longint unsigned size();
      longint unsigned s;
      s = ring_reg;
      if (s == 0) s = 1;
      if (s > 65536) s = 65536;
      return s;
    endfunction

    function void write_size(logic [31:0] v);
      ring_reg = v[16:0];
      restart();
    endfunction

    function void advance(longint unsigned n, longint unsigned s);
      head += n;
      if (head == s) begin
        lap++;
        head = 0;
        wend = s;
      end else if (wend < head) begin
        wend = head;
      end
    endfunction

    function void wrap();
      wend = head;
      head = 0;
      lap++;
    endfunction

    function void note_request(logic [2:0] act, logic [16:0] len, logic [2:0] rd, bit rep);
      longint unsigned s, n, off, pend, noff, npend, avail, half;
      logic [31:0] rl;
      bit commit;
      ring_result_t e;
      s = size();
      n = len;
      e = '0;
      if (act == ACT_ADD) begin
        if (n > s) e.status = ST_ERROR;
        else begin
          avail = s - head;
          if (avail >= n) advance(n, s);
          else begin
            wend = s;
            lap++;
            head = n - avail;
          end
        end
      end else if (act == ACT_REQUEST) begin
        if (n > s) e.status = ST_ERROR;
        else begin
          if (s - head < n) wrap();
          wblk_ok = 1;
          wblk_at = head;
          e.boff = head[15:0];
          e.bbytes = 17'(s - head);
          e.blap = lap;
        end
      end else if (act == ACT_WROTE) begin
        if (!wblk_ok || wblk_at != head || n > s - head) e.status = ST_ERROR;
        else advance(n, s);
      end else if (act == ACT_WRAP) begin
        wrap();
      end else if (act == ACT_UNUSED) begin
        e.status = ST_ERROR;
      end else begin
        off = rd_off[rd];
        rl = rd_lap[rd];
        pend = rd_pend[rd];
        commit = 1;
        if (act == ACT_JOIN) begin
          half = s / 2;
          rl = lap;
          off = head;
          pend = 0;
          if (rep) begin
            if (head >= half) off = head - half;
            else if (lap == 0) off = 0;
            else begin
              rl = lap - 1;
              off = head + wend / 2;
            end
          end
        end else if (lap > 32'(rl + 1) || (lap > rl && head > off)) begin
          e.status = ST_OVERRUN;
          off = head;
          rl = lap;
          pend = 0;
        end else if (act == ACT_NEXT) begin
          if (head > off) pend = head - off;
          else if (lap == 32'(rl + 1) && wend == off) begin
            off = 0;
            rl++;
            pend = head;
          end else if (lap > rl) pend = (wend > off) ? wend - off : 0;
        end else begin
          noff = off + n;
          npend = (pend > n) ? pend - n : 0;
          if (noff > wend) commit = 0;
          else if (noff == wend && noff != head) begin
            if (npend != 0) commit = 0;
            else begin
              off = 0;
              rl++;
              pend = 0;
            end
          end else begin
            off = noff;
            pend = npend;
          end
          if (!commit) e.status = ST_ERROR;
        end
        if (commit) begin
          rd_off[rd] = off;
          rd_lap[rd] = rl;
          rd_pend[rd] = pend;
          e.boff = off[15:0];
          e.bbytes = pend[16:0];
          e.blap = rl;
        end
      end
      e.hoff = head[15:0];
      e.hlap = lap;
      if (e.status == ST_OVERRUN) n_ovr++;
      if (e.status == ST_ERROR) n_err++;
      pending_q.push_back(e);
    endfunction

    function void check_result(ring_result_t got);
      ring_result_t e;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending_q.pop_front();
      if (e.status !== got.status || e.boff !== got.boff || e.bbytes !== got.bbytes ||
          e.blap !== got.blap || e.hoff !== got.hoff || e.hlap !== got.hlap) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d off=%0d bytes=%0d lap=%0d head=%0d hlap=%0d",
                   e.status, e.boff, e.bbytes, e.blap, e.hoff, e.hlap,
                   " / got st=%0d off=%0d bytes=%0d lap=%0d head=%0d hlap=%0d",
                   got.status, got.boff, got.bbytes, got.blap, got.hoff, got.hlap);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [6:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [119:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  ring_scoreboard sb = new();
  int cycles = 0;
  int hold_off = 0;
  int items_sent = 0;
  bit [NRD-1:0] joined = '0;

  always #2 clk = ~clk;

  multi_reader_ring_pointer_manager uut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_reader_ring_pointer_manager regression: fail");
      $finish;
    end
  end

  // receiver: stall pattern plus one long hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tuser, out_tdata[15:0], out_tdata[32:16], out_tdata[64:33],
                       out_tdata[80:65], out_tdata[112:81]});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else if (cycles[9:7] == 3'd2) begin
      out_tready <= 1;
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send(logic [2:0] act, logic [16:0] len, logic [2:0] rd, bit rep);
    in_tvalid <= 1;
    in_tdata <= {7'd0, len};
    in_tuser <= {rep, rd, act};
    do @(posedge clk); while (!in_tready);
    sb.note_request(act, len, rd, rep);
    items_sent++;
    if (act == ACT_JOIN) joined[rd] = 1;
  endtask

  task automatic pause(int n);
    in_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 0;
    while (sb.pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ring(logic [31:0] v);
    drain();
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_penable <= 0;
    cfg_paddr <= '0;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_size(v);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
  endtask

  function automatic logic [2:0] pick_reader();
    logic [2:0] r;
    r = 3'($urandom_range(0, NRD - 1));
    for (int i = 0; i < NRD && !joined[r]; i++) r = r + 1;
    return r;
  endfunction

  task automatic random_item();
    int w;
    longint unsigned s, ln;
    logic [2:0] r;
    s = sb.size();
    w = $urandom_range(0, 99);
    r = pick_reader();
    if (w < 3 && joined != '0) begin
      send(3'($urandom_range(0, 7)), 17'($urandom), r, 1'($urandom));
    end else if (w < 16) begin
      ln = ($urandom_range(0, 9) == 0) ? $urandom_range(0, s) : $urandom_range(0, s / 3);
      send(ACT_ADD, 17'(ln), 3'($urandom), 1'($urandom));
    end else if (w < 36) begin
      send(ACT_REQUEST, 17'($urandom_range(0, s)), 3'($urandom), 1'($urandom));
      ln = (sb.wblk_ok && $urandom_range(0, 7) != 0) ?
           $urandom_range(0, (s - sb.head) > 0 ? (s - sb.head) : 0) : $urandom_range(0, s);
      if ($urandom_range(0, 3) == 0) ln = $urandom_range(0, (s - sb.head) / 4);
      send(ACT_WROTE, 17'(ln), 3'($urandom), 1'($urandom));
    end else if (w < 40) begin
      send(ACT_WRAP, 17'($urandom), 3'($urandom), 1'($urandom));
    end else if (w < 48 || joined == '0) begin
      send(ACT_JOIN, 17'($urandom), 3'($urandom), 1'($urandom));
    end else if (w < 70) begin
      send(ACT_NEXT, 17'($urandom), r, 1'($urandom));
    end else if (w < 98) begin
      ln = sb.rd_pend[r];
      if ($urandom_range(0, 4) == 0) ln = ln + $urandom_range(0, 8);
      else if ($urandom_range(0, 2) == 0) ln = $urandom_range(0, ln);
      send(ACT_CONSUMED, 17'(ln), r, 1'($urandom));
    end else begin
      send(ACT_ADD, 17'($urandom_range(0, 131071)), 3'($urandom), 1'($urandom));
    end
  endtask

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && n > 0) begin
        random_item();
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [31:0] sizes [7];
    sizes = '{32'd16, 32'd1, 32'd0, 32'd300, 32'h0001FFFF, 32'hFFFF0011, 32'd1000};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, each action and the special cases
    send(ACT_WROTE, 17'd0, 3'd0, 0);
    send(ACT_ADD, 17'h10001, 3'd0, 0);
    send(ACT_ADD, 17'h1FFFF, 3'd7, 1);
    send(ACT_JOIN, 17'd0, 3'd0, 1);
    send(ACT_ADD, 17'd40000, 3'd0, 0);
    send(ACT_JOIN, 17'd0, 3'd1, 1);
    send(ACT_NEXT, 17'd0, 3'd0, 0);
    send(ACT_CONSUMED, 17'd50000, 3'd0, 0);
    send(ACT_CONSUMED, 17'd100, 3'd0, 0);
    send(ACT_REQUEST, 17'd30000, 3'd0, 0);
    send(ACT_WROTE, 17'd30000, 3'd0, 0);
    send(ACT_WROTE, 17'd10, 3'd0, 0);
    send(ACT_ADD, 17'h10000, 3'd0, 0);
    send(ACT_JOIN, 17'd0, 3'd2, 1);
    send(ACT_NEXT, 17'd0, 3'd1, 0);
    send(ACT_ADD, 17'd65000, 3'd0, 0);
    send(ACT_NEXT, 17'd0, 3'd0, 0);
    send(ACT_WRAP, 17'd0, 3'd0, 0);
    send(ACT_REQUEST, 17'h10000, 3'd0, 0);
    send(ACT_WROTE, 17'h10000, 3'd0, 0);
    send(ACT_NEXT, 17'd0, 3'd2, 0);
    send(ACT_UNUSED, 17'd0, 3'd0, 0);
    send(ACT_JOIN, 17'd0, 3'd7, 0);
    send(ACT_NEXT, 17'd0, 3'd7, 1);
    random_phase(150);

    // long receiver hold-off while the sender keeps offering
    hold_off = 300;
    random_phase(60);

    foreach (sizes[i]) begin
      write_ring(sizes[i]);
      random_phase(150);
    end
    write_ring(32'h00010000);
    random_phase(40);

    drain();
    repeat (20) @(posedge clk);
    $display("sent %0d requests across 8 ring sizes (0 to 131071), checked %0d results",
             items_sent, sb.checked);
    $display("overruns %0d, error statuses %0d, leftover %0d, mismatches %0d",
             sb.n_ovr, sb.n_err, sb.pending_q.size(), sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("multi_reader_ring_pointer_manager regression: pass");
    else
      $display("multi_reader_ring_pointer_manager regression: fail");
    $finish;
  end
endmodule
